// ===== src/esds_pkg.sv =====
// Shared constants and register map for the SCAN elevator disk scheduler.
package esds_pkg;

  localparam int unsigned MAX_REQUESTS_DEF  = 32;
  localparam int unsigned CYLINDER_BITS_DEF = 16;
  localparam int unsigned PADDR_W           = 4;
  localparam int unsigned PDATA_W           = 32;

  typedef enum logic [1:0] {
    REG_START_CYL = 2'd0,
    REG_MAX_CYL   = 2'd1,
    REG_START_UP  = 2'd2
  } reg_idx_e;

endpackage

// ===== src/esds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module esds_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/elevator_scan_disk_scheduler.sv =====
// SCAN elevator disk scheduler: sorted request store in RAM, schedule walk on last word.
// Load: a word is taken while idle, then sorted in with one RAM shift per cycle,
//   as the request store has a single read and a single write port.
// Schedule: two walks over the store at one entry per cycle while the output is not stalled,
//   with a sweep state between them and a flush state after; each result waits in a pending
//   register for the next, and the flush state sends the last one with tlast.
// Reset: asynchronous, active low; clears control, restores configuration defaults, not the store.
module elevator_scan_disk_scheduler #(
  parameter int unsigned MAX_REQUESTS  = esds_pkg::MAX_REQUESTS_DEF,
  parameter int unsigned CYLINDER_BITS = esds_pkg::CYLINDER_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [esds_pkg::PADDR_W-1:0]                 paddr,
  input  logic [esds_pkg::PDATA_W-1:0]                 pwdata,
  output logic [esds_pkg::PDATA_W-1:0]                 prdata,
  output logic                                         pready,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // request_cylinder
  input  logic [((CYLINDER_BITS+7)/8)*8-1:0]           s_axis_tdata,
  input  logic                                         s_axis_tlast,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // target_cylinder, total_seek
  output logic [((2*CYLINDER_BITS+8)/8)*8-1:0]         m_axis_tdata,
  // serviced, moving_up
  output logic [1:0]                                   m_axis_tuser,
  output logic                                         m_axis_tlast
);

  localparam int unsigned CB    = CYLINDER_BITS;
  localparam int unsigned SW    = CYLINDER_BITS + 1;
  localparam int unsigned AW    = $clog2(MAX_REQUESTS);
  localparam int unsigned CW    = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned OUT_W = ((2*CYLINDER_BITS+8)/8)*8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_WALK1,
    ST_SWEEP,
    ST_WALK2,
    ST_FLUSH
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   j_q, j_d;
  logic [CW-1:0]   k_q, k_d;
  logic [CB-1:0]   req_q, req_d;
  logic            last_q, last_d;
  logic [CB-1:0]   start_q, start_d;
  logic            up_q, up_d;
  logic [CB-1:0]   head_q, head_d;
  logic [SW-1:0]   seek_q, seek_d;

  logic            pend_vld_q, pend_vld_d;
  logic [CB-1:0]   pend_tgt_q, pend_tgt_d;
  logic            pend_srv_q, pend_srv_d;
  logic            pend_up_q, pend_up_d;
  logic [SW-1:0]   pend_seek_q, pend_seek_d;

  logic            m_vld_q, m_vld_d;
  logic [CB-1:0]   m_tgt_q, m_tgt_d;
  logic            m_srv_q, m_srv_d;
  logic            m_up_q, m_up_d;
  logic [SW-1:0]   m_seek_q, m_seek_d;
  logic            m_last_q, m_last_d;

  logic            fwd_hit_q, fwd_hit_d;
  logic [CB-1:0]   fwd_data_q, fwd_data_d;

  logic [CB-1:0]   cfg_start_q, cfg_max_q;
  logic            cfg_up_q;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [CB-1:0]   wdata, rdata, rd_word;

  logic [CB-1:0]   in_cyl, req_clip, start_eff;
  logic            out_free, can_gen, sched, qual, asc;
  logic            gen_req, gen_srv, gen_up;
  logic [CB-1:0]   gen_tgt, move_len;
  logic            cfg_wr;

  esds_ram #(
    .WIDTH (CB),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign in_cyl   = s_axis_tdata[CB-1:0];
  assign req_clip = (in_cyl > cfg_max_q) ? cfg_max_q : in_cyl;
  assign start_eff = (cfg_start_q > cfg_max_q) ? cfg_max_q : cfg_start_q;
  assign out_free = !m_vld_q || m_axis_tready;
  assign can_gen  = !pend_vld_q || out_free;
  assign move_len = (gen_tgt >= head_q) ? gen_tgt - head_q : head_q - gen_tgt;
  assign rd_word  = fwd_hit_q ? fwd_data_q : rdata;
  assign fwd_hit_d  = we && (waddr == raddr);
  assign fwd_data_d = wdata;

  always_comb begin
    case (esds_pkg::reg_idx_e'(paddr[3:2]))
      esds_pkg::REG_START_CYL: prdata = esds_pkg::PDATA_W'(cfg_start_q);
      esds_pkg::REG_MAX_CYL:   prdata = esds_pkg::PDATA_W'(cfg_max_q);
      esds_pkg::REG_START_UP:  prdata = esds_pkg::PDATA_W'(cfg_up_q);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    j_d         = j_q;
    k_d         = k_q;
    req_d       = req_q;
    last_d      = last_q;
    start_d     = start_q;
    up_d        = up_q;
    head_d      = head_q;
    seek_d      = seek_q;
    pend_vld_d  = pend_vld_q;
    pend_tgt_d  = pend_tgt_q;
    pend_srv_d  = pend_srv_q;
    pend_up_d   = pend_up_q;
    pend_seek_d = pend_seek_q;
    m_vld_d     = m_vld_q && !m_axis_tready;
    m_tgt_d     = m_tgt_q;
    m_srv_d     = m_srv_q;
    m_up_d      = m_up_q;
    m_seek_d    = m_seek_q;
    m_last_d    = m_last_q;
    we          = 1'b0;
    waddr       = AW'(j_q);
    wdata       = req_q;
    sched       = 1'b0;
    qual        = 1'b0;
    gen_req     = 1'b0;
    gen_tgt     = rd_word;
    gen_srv     = 1'b1;
    gen_up      = up_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d  = req_clip;
          last_d = s_axis_tlast;
          if (count_q == CW'(MAX_REQUESTS)) begin
            sched = s_axis_tlast;
          end else begin
            j_d     = count_q;
            state_d = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        we = 1'b1;
        if (j_q == '0 || rd_word <= req_q) begin
          wdata   = req_q;
          count_d = count_q + CW'(1);
          if (last_q) begin
            sched = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          wdata = rd_word;
          j_d   = j_q - CW'(1);
        end
      end
      ST_WALK1, ST_WALK2: begin
        if (state_q == ST_WALK1) begin
          qual   = up_q ? (rd_word >= start_q) : (rd_word <= start_q);
          gen_up = up_q;
        end else begin
          qual   = up_q ? (rd_word < start_q) : (rd_word > start_q);
          gen_up = !up_q;
        end
        gen_req = qual;
        if (!qual || can_gen) begin
          k_d = k_q + CW'(1);
          if (k_q == count_q - CW'(1)) begin
            k_d     = '0;
            state_d = (state_q == ST_WALK1) ? ST_SWEEP : ST_FLUSH;
          end
        end
      end
      ST_SWEEP: begin
        gen_tgt = up_q ? cfg_max_q : '0;
        gen_srv = 1'b0;
        gen_up  = up_q;
        if (head_q == gen_tgt) begin
          state_d = ST_WALK2;
        end else begin
          gen_req = 1'b1;
          if (can_gen) begin
            state_d = ST_WALK2;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          m_vld_d    = pend_vld_q;
          m_tgt_d    = pend_tgt_q;
          m_srv_d    = pend_srv_q;
          m_up_d     = pend_up_q;
          m_seek_d   = pend_seek_q;
          m_last_d   = 1'b1;
          pend_vld_d = 1'b0;
          count_d    = '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (sched) begin
      state_d = ST_WALK1;
      start_d = start_eff;
      head_d  = start_eff;
      seek_d  = '0;
      up_d    = cfg_up_q;
      k_d     = '0;
    end

    if (gen_req && can_gen) begin
      if (pend_vld_q) begin
        m_vld_d  = 1'b1;
        m_tgt_d  = pend_tgt_q;
        m_srv_d  = pend_srv_q;
        m_up_d   = pend_up_q;
        m_seek_d = pend_seek_q;
        m_last_d = 1'b0;
      end
      pend_vld_d  = 1'b1;
      pend_tgt_d  = gen_tgt;
      pend_srv_d  = gen_srv;
      pend_up_d   = gen_up;
      pend_seek_d = seek_q + SW'(move_len);
      head_d      = gen_tgt;
      seek_d      = seek_q + SW'(move_len);
    end
  end

  always_comb begin
    asc   = (state_d == ST_WALK1) ? up_d : !up_d;
    raddr = '0;
    case (state_d)
      ST_INSERT: raddr = AW'(j_d - CW'(1));
      ST_WALK1, ST_WALK2: begin
        raddr = asc ? AW'(k_d) : AW'(count_d - CW'(1) - k_d);
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      j_q         <= '0;
      k_q         <= '0;
      req_q       <= '0;
      last_q      <= 1'b0;
      start_q     <= '0;
      up_q        <= 1'b1;
      head_q      <= '0;
      seek_q      <= '0;
      pend_vld_q  <= 1'b0;
      pend_tgt_q  <= '0;
      pend_srv_q  <= 1'b0;
      pend_up_q   <= 1'b0;
      pend_seek_q <= '0;
      m_vld_q     <= 1'b0;
      m_tgt_q     <= '0;
      m_srv_q     <= 1'b0;
      m_up_q      <= 1'b0;
      m_seek_q    <= '0;
      m_last_q    <= 1'b0;
      fwd_hit_q   <= 1'b0;
      fwd_data_q  <= '0;
      cfg_start_q <= '0;
      cfg_max_q   <= '1;
      cfg_up_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      j_q         <= j_d;
      k_q         <= k_d;
      req_q       <= req_d;
      last_q      <= last_d;
      start_q     <= start_d;
      up_q        <= up_d;
      head_q      <= head_d;
      seek_q      <= seek_d;
      pend_vld_q  <= pend_vld_d;
      pend_tgt_q  <= pend_tgt_d;
      pend_srv_q  <= pend_srv_d;
      pend_up_q   <= pend_up_d;
      pend_seek_q <= pend_seek_d;
      m_vld_q     <= m_vld_d;
      m_tgt_q     <= m_tgt_d;
      m_srv_q     <= m_srv_d;
      m_up_q      <= m_up_d;
      m_seek_q    <= m_seek_d;
      m_last_q    <= m_last_d;
      fwd_hit_q   <= fwd_hit_d;
      fwd_data_q  <= fwd_data_d;
      if (cfg_wr) begin
        case (esds_pkg::reg_idx_e'(paddr[3:2]))
          esds_pkg::REG_START_CYL: cfg_start_q <= pwdata[CB-1:0];
          esds_pkg::REG_MAX_CYL:   cfg_max_q   <= pwdata[CB-1:0];
          esds_pkg::REG_START_UP:  cfg_up_q    <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = OUT_W'({m_seek_q, m_tgt_q});
  assign m_axis_tuser  = {m_up_q, m_srv_q};
  assign m_axis_tlast  = m_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_REQUESTS))
    else $error("request count beyond store depth");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT) |-> (j_q <= count_q))
    else $error("insert slot beyond filled entries");

  a_seek_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK1 || state_q == ST_SWEEP || state_q == ST_WALK2 ||
     state_q == ST_FLUSH) |-> (seek_q <= {cfg_max_q, 1'b0}))
    else $error("seek total beyond two full strokes");

  a_pend_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> pend_vld_q)
    else $error("schedule ended without a pending result");
`endif

endmodule
